/* rtl/vca_pkg.sv */
// Shared types and constants for the voice channel allocator.
// No dependencies; used by vca_cell and voice_channel_allocator.
`default_nettype none

package vca_pkg;

	localparam int CH_IDX_W = 5;   // holds any channel index up to 31
	localparam int PRI_W    = 8;
	localparam int TRK_W    = 4;
	localparam int CFG_W    = 4;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	localparam logic [CFG_W-1:0] CIU_RESET = 4'd12;

	typedef struct packed {
		logic             on;
		logic             stopping;
		logic [PRI_W-1:0] priority_v;
		logic [TRK_W-1:0] track;
	} entry_t;

	typedef struct packed {
		logic   en;
		logic   [3:0] index;
		entry_t entry;
	} wr_t;

	// Running search state passed from cell to cell.
	typedef struct packed {
		logic                vld;
		logic [PRI_W-1:0]    req_pri;
		logic [PRI_W-1:0]    best_pri;
		logic [TRK_W-1:0]    best_trk;
		logic                best_stop;
		logic                have_best;
		logic                free_hit;
		logic [CH_IDX_W-1:0] best_idx;
	} scan_t;

endpackage

`default_nettype wire

/* rtl/voice_channel_allocator.sv */
// Top level: channel entry cells chained into a search row, request control,
// result holding stage and the configuration port. Depends on vca_pkg, vca_cell.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_stall  req_type, entry_*, request_*
//   result    out        res_valid/res_stall  granted, chosen_*
//   config    in         APB psel/penable     channels_in_use, written when paddr[2] is 0
//
// A write transfer updates its entry at acceptance; its result passes the pending
// register and then the output register. An allocate transfer walks the row of
// NUM_CHANNELS cells, one cell per cycle, and its result then takes the same path.
// One request is in flight at a time; a new one is taken once the previous
// result has reached the output register, which may still be stalled.
// Reset clears every entry to off and channels_in_use to 12.
`default_nettype none

module voice_channel_allocator #(
	parameter int NUM_CHANNELS = 12
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [2:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	input  wire        req_valid,
	output logic       req_stall,
	input  wire        req_type,
	input  wire [3:0]  entry_index,
	input  wire        entry_on,
	input  wire        entry_stopping,
	input  wire [7:0]  entry_priority,
	input  wire [3:0]  entry_track,
	input  wire [7:0]  request_priority,
	input  wire [3:0]  request_track,
	output logic       res_valid,
	input  wire        res_stall,
	output logic       granted,
	output logic [3:0] chosen_channel,
	output logic       chosen_was_free,
	output logic       chosen_was_stopping
);

	logic [vca_pkg::CFG_W-1:0] ciu_q;
	logic                      busy_q;
	logic                      pend_valid_q;
	logic                      pend_grant_q;
	logic [3:0]                pend_chan_q;
	logic                      pend_free_q;
	logic                      pend_stop_q;
	logic                      res_valid_q;
	logic                      res_grant_q;
	logic [3:0]                res_chan_q;
	logic                      res_free_q;
	logic                      res_stop_q;

	logic                      req_acc;
	logic                      wr_acc;
	logic                      alloc_acc;
	logic                      scan_done;
	logic                      move;
	logic                      fin_grant;
	logic                      fin_free;
	logic                      fin_stop;
	logic [NUM_CHANNELS-1:0]   scan_vld;
	vca_pkg::wr_t              wr;
	vca_pkg::scan_t            scan [0:NUM_CHANNELS];
	vca_pkg::scan_t            last;

	// configuration port
	assign pready = 1'b1;
	assign prdata = {{(32-vca_pkg::CFG_W){1'b0}}, ciu_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q <= vca_pkg::CIU_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			ciu_q <= pwdata[vca_pkg::CFG_W-1:0];
		end
	end

	// request side
	assign req_stall = busy_q || pend_valid_q;
	assign req_acc   = req_valid && !req_stall;
	assign wr_acc    = req_acc && (req_type == vca_pkg::REQ_WRITE);
	assign alloc_acc = req_acc && (req_type == vca_pkg::REQ_ALLOC);

	always_comb begin
		wr.en               = wr_acc;
		wr.index            = entry_index;
		wr.entry.on         = entry_on;
		wr.entry.stopping   = entry_stopping;
		wr.entry.priority_v = entry_priority;
		wr.entry.track      = entry_track;

		// the best starts at the request's own priority and track
		scan[0].vld       = alloc_acc;
		scan[0].req_pri   = request_priority;
		scan[0].best_pri  = request_priority;
		scan[0].best_trk  = request_track;
		scan[0].best_stop = 1'b0;
		scan[0].have_best = 1'b0;
		scan[0].free_hit  = 1'b0;
		scan[0].best_idx  = '0;
	end

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		vca_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (wr),
			.limit    (ciu_q),
			.scan_in  (scan[i]),
			.scan_out (scan[i+1])
		);
		assign scan_vld[i] = scan[i+1].vld;
	end

	assign last      = scan[NUM_CHANNELS];
	assign scan_done = last.vld;

	always_comb begin
		fin_grant = 1'b0;
		fin_free  = 1'b0;
		fin_stop  = 1'b0;
		if (last.free_hit) begin
			fin_grant = 1'b1;
			fin_free  = 1'b1;
		end else if (last.have_best && (last.best_stop || (last.req_pri >= last.best_pri))) begin
			fin_grant = 1'b1;
			fin_stop  = last.best_stop;
		end
	end

	assign move = pend_valid_q && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (alloc_acc) begin
				busy_q <= 1'b1;
			end else if (scan_done) begin
				busy_q <= 1'b0;
			end

			if (wr_acc || scan_done) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end

			if (move) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			pend_grant_q <= 1'b0;
			pend_chan_q  <= '0;
			pend_free_q  <= 1'b0;
			pend_stop_q  <= 1'b0;
		end else if (scan_done) begin
			pend_grant_q <= fin_grant;
			pend_chan_q  <= fin_grant ? last.best_idx[3:0] : 4'd0;
			pend_free_q  <= fin_free;
			pend_stop_q  <= fin_stop;
		end
		if (move) begin
			res_grant_q <= pend_grant_q;
			res_chan_q  <= pend_chan_q;
			res_free_q  <= pend_free_q;
			res_stop_q  <= pend_stop_q;
		end
	end

	assign res_valid           = res_valid_q;
	assign granted             = res_grant_q;
	assign chosen_channel      = res_chan_q;
	assign chosen_was_free     = res_free_q;
	assign chosen_was_stopping = res_stop_q;

	// an allocate transfer leaves the row once it has passed the scan register of every cell
	a_scan_latency: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_acc |-> ##NUM_CHANNELS scan_done)
		else $error("scan did not complete on time");

	a_one_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(scan_vld) <= 1)
		else $error("more than one search in the cell row");

	a_busy_pend: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && pend_valid_q))
		else $error("pending result while a search is still running");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> busy_q)
		else $error("search completed with no request in flight");

endmodule

`default_nettype wire

/* rtl/vca_cell.sv */
// One channel entry and its step of the allocation search.
// Depends on vca_pkg.
`default_nettype none

module vca_cell #(
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire vca_pkg::wr_t   wr,
	input  wire [3:0]           limit,
	input  wire vca_pkg::scan_t scan_in,
	output vca_pkg::scan_t      scan_out
);

	vca_pkg::entry_t entry_q;
	vca_pkg::scan_t  scan_q;
	vca_pkg::scan_t  scan_d;
	logic            beats;
	logic            active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr.en && (int'(wr.index) == IDX)) begin
			entry_q <= wr.entry;
		end
	end

	always_comb begin
		beats  = (entry_q.priority_v < scan_in.best_pri) ||
			((entry_q.priority_v == scan_in.best_pri) && (entry_q.track >= scan_in.best_trk));
		active = scan_in.vld && !scan_in.free_hit && (IDX < int'(limit));
		scan_d = scan_in;
		if (active) begin
			if (!entry_q.on) begin
				scan_d.free_hit = 1'b1;
				scan_d.best_idx = vca_pkg::CH_IDX_W'(IDX);
			end else if (entry_q.stopping) begin
				if (!scan_in.best_stop || beats) begin
					scan_d.best_stop = 1'b1;
					scan_d.have_best = 1'b1;
					scan_d.best_pri  = entry_q.priority_v;
					scan_d.best_trk  = entry_q.track;
					scan_d.best_idx  = vca_pkg::CH_IDX_W'(IDX);
				end
			end else if (!scan_in.best_stop && beats) begin
				scan_d.have_best = 1'b1;
				scan_d.best_pri  = entry_q.priority_v;
				scan_d.best_trk  = entry_q.track;
				scan_d.best_idx  = vca_pkg::CH_IDX_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	assign scan_out = scan_q;

endmodule

`default_nettype wire
